@@ design/csf_pkg.sv @@
// Shared types and constants for the outgoing-call sequencer.
`default_nettype none

package csf_pkg;

  localparam int SLOT_W      = 4;
  localparam int ELAPSED_W   = 17;
  localparam int BEEP_W      = 16;
  localparam int BLINK_W     = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int SLOT_COUNT_DEFAULT = 16;

  localparam logic [15:0]        HOLD_TIME_RST    = 16'd25000;
  localparam logic [15:0]        BEEP_PERIOD_RST  = 16'd3000;
  localparam logic [BLINK_W-1:0] BLINK_PERIOD_RST = 10'd300;
  localparam logic [BLINK_W-1:0] BLINK_ON_RST     = 10'd100;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [BEEP_W-1:0]    BEEP_MAX    = '1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEIZE   = 3'd1,
    PH_DIAL    = 3'd2,
    PH_HOLD    = 3'd3,
    PH_RELEASE = 3'd4
  } csf_phase_t;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_REQUEST = 1'b1
  } csf_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_TIME    = 3'd0,
    CFG_BEEP_PERIOD  = 3'd1,
    CFG_BLINK_PERIOD = 3'd2,
    CFG_BLINK_ON     = 3'd3
  } csf_cfg_idx_t;

  typedef struct packed {
    logic              opcode;
    logic [SLOT_W-1:0] number_slot;
    logic              hook_stable_on;
    logic              hook_stable_off;
    logic              dialer_busy;
    logic              dialer_led;
  } csf_in_t;

  typedef struct packed {
    logic              hook_drive;
    logic              start_dial;
    logic [SLOT_W-1:0] dial_slot;
    logic              start_beep;
    logic              call_active;
    logic              led_level;
    logic              call_refused;
  } csf_out_t;

  typedef struct packed {
    logic [15:0]        hold_time_ms;
    logic [15:0]        beep_period_ms;
    logic [BLINK_W-1:0] blink_period_ms;
    logic [BLINK_W-1:0] blink_on_ms;
  } csf_cfg_t;

  typedef struct packed {
    csf_phase_t           phase;
    logic [ELAPSED_W-1:0] phase_elapsed;
    logic [BEEP_W-1:0]    beep_elapsed;
    logic [BLINK_W-1:0]   blink_pos;
    logic [SLOT_W-1:0]    pending_slot;
    logic                 hook_level;
  } csf_state_t;

endpackage

`default_nettype wire

@@ design/call_sequencer_fsm.sv @@
// Top level of the outgoing-call sequencer: input register, state, result register.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_word   (csf_in_t)
//   out_    | output    | out_valid/out_stall| out_word  (csf_out_t)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word in per cycle while in_stall is low; each taken word passes through the input
// register, then through the state update into the result register.
// rst_n low puts the call in release phase with counters cleared and config at defaults.
// A stalled result holds; the input register still takes one more word behind it.
// cfg_ready is always high; one register write per cycle.
`default_nettype none

module call_sequencer_fsm #(
  parameter int SLOT_COUNT = csf_pkg::SLOT_COUNT_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  csf_pkg::csf_in_t                   in_word,
  output logic                               out_valid,
  input  wire                                out_stall,
  output csf_pkg::csf_out_t                  out_word,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [csf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [csf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import csf_pkg::*;

  csf_cfg_t   cfg_r;
  csf_state_t state_r;
  csf_state_t state_nxt;
  csf_in_t    in_word_r;
  logic       in_valid_r;
  csf_out_t   out_word_r;
  csf_out_t   out_word_nxt;
  logic       out_valid_r;
  logic       advance;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

  csf_step #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_step (
    .state_cur(state_r),
    .cfg      (cfg_r),
    .word_in  (in_word_r),
    .state_nxt(state_nxt),
    .word_out (out_word_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time_ms    <= HOLD_TIME_RST;
      cfg_r.beep_period_ms  <= BEEP_PERIOD_RST;
      cfg_r.blink_period_ms <= BLINK_PERIOD_RST;
      cfg_r.blink_on_ms     <= BLINK_ON_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOLD_TIME:    cfg_r.hold_time_ms    <= cfg_data;
        CFG_BEEP_PERIOD:  cfg_r.beep_period_ms  <= cfg_data;
        CFG_BLINK_PERIOD: cfg_r.blink_period_ms <= cfg_data[BLINK_W-1:0];
        CFG_BLINK_ON:     cfg_r.blink_on_ms     <= cfg_data[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_RELEASE;
      state_r.phase_elapsed <= '0;
      state_r.beep_elapsed  <= '0;
      state_r.blink_pos     <= '0;
      state_r.pending_slot  <= '0;
      state_r.hook_level    <= 1'b0;
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        // state moves only when a word passes into the result register
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
    if (advance && in_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  a_dial_hooked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.start_dial |-> out_word_r.hook_drive && out_word_r.call_active)
    else $error("start_dial without seized line");

  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.start_dial && out_word_r.start_beep)
                    && !(out_word_r.call_refused
                         && (out_word_r.start_dial || out_word_r.start_beep)))
    else $error("conflicting pulses in one result");

  a_dial_from_seize: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_DIAL) && ($past(state_r.phase) != PH_DIAL)
      |-> $past(state_r.phase) == PH_SEIZE)
    else $error("dial phase entered from a phase other than seize");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && in_valid_r) |=> $stable(state_r))
    else $error("state changed with no word processed");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room to advance");

endmodule

`default_nettype wire

@@ design/csf_step.sv @@
// Next-state and result logic for one word of the call sequencer.
`default_nettype none

module csf_step #(
  parameter int SLOT_COUNT = csf_pkg::SLOT_COUNT_DEFAULT
) (
  input  csf_pkg::csf_state_t state_cur,
  input  csf_pkg::csf_cfg_t   cfg,
  input  csf_pkg::csf_in_t    word_in,
  output csf_pkg::csf_state_t state_nxt,
  output csf_pkg::csf_out_t   word_out
);
  import csf_pkg::*;

  logic [BLINK_W:0] blink_inc;
  logic             slot_ok;

  assign slot_ok = (32'(word_in.number_slot) < SLOT_COUNT);

  always_comb begin
    state_nxt = state_cur;
    word_out  = '0;
    blink_inc = {1'b0, state_cur.blink_pos} + 1'b1;

    if (word_in.opcode == OP_REQUEST) begin
      if (state_cur.phase != PH_IDLE || !slot_ok) begin
        word_out.call_refused = 1'b1;
      end else begin
        state_nxt.pending_slot  = word_in.number_slot;
        state_nxt.phase         = PH_SEIZE;
        state_nxt.phase_elapsed = '0;
        state_nxt.beep_elapsed  = '0;
        state_nxt.blink_pos     = '0;
      end
    end else begin
      // advance counters first, then act on the phase
      if (state_cur.phase_elapsed != ELAPSED_MAX) begin
        state_nxt.phase_elapsed = state_cur.phase_elapsed + 1'b1;
      end
      if (state_cur.beep_elapsed != BEEP_MAX) begin
        state_nxt.beep_elapsed = state_cur.beep_elapsed + 1'b1;
      end
      state_nxt.blink_pos = (blink_inc >= {1'b0, cfg.blink_period_ms}) ? '0
                                                                        : blink_inc[BLINK_W-1:0];

      unique case (state_cur.phase)
        PH_IDLE: begin
          state_nxt.hook_level = 1'b0;
        end
        PH_SEIZE: begin
          state_nxt.hook_level = 1'b1;
          if (word_in.hook_stable_on) begin
            state_nxt.phase         = PH_DIAL;
            state_nxt.phase_elapsed = '0;
            state_nxt.beep_elapsed  = '0;
            state_nxt.blink_pos     = '0;
            word_out.start_dial     = 1'b1;
            word_out.dial_slot      = state_cur.pending_slot;
          end
        end
        PH_DIAL: begin
          if (!word_in.dialer_busy) begin
            state_nxt.phase         = PH_HOLD;
            state_nxt.phase_elapsed = '0;
            state_nxt.beep_elapsed  = '0;
            state_nxt.blink_pos     = '0;
          end
        end
        PH_HOLD: begin
          if (state_nxt.phase_elapsed > {1'b0, cfg.hold_time_ms}) begin
            state_nxt.phase         = PH_RELEASE;
            state_nxt.phase_elapsed = '0;
            state_nxt.beep_elapsed  = '0;
            state_nxt.blink_pos     = '0;
          end else if (state_nxt.beep_elapsed > cfg.beep_period_ms) begin
            state_nxt.beep_elapsed = '0;
            word_out.start_beep    = 1'b1;
          end
        end
        PH_RELEASE: begin
          state_nxt.hook_level = 1'b0;
          if (word_in.hook_stable_off) begin
            state_nxt.phase         = PH_IDLE;
            state_nxt.phase_elapsed = '0;
            state_nxt.beep_elapsed  = '0;
            state_nxt.blink_pos     = '0;
          end
        end
        default: begin
          // unused codes drop to idle, hook untouched
          state_nxt.phase         = PH_IDLE;
          state_nxt.phase_elapsed = '0;
          state_nxt.beep_elapsed  = '0;
          state_nxt.blink_pos     = '0;
        end
      endcase
    end

    word_out.hook_drive  = state_nxt.hook_level;
    word_out.call_active = (state_nxt.phase != PH_IDLE);
    case (state_nxt.phase)
      PH_SEIZE: word_out.led_level = 1'b1;
      PH_DIAL:  word_out.led_level = word_in.dialer_led;
      PH_HOLD:  word_out.led_level = (state_nxt.blink_pos < cfg.blink_on_ms);
      default:  word_out.led_level = 1'b0;
    endcase
  end

endmodule

`default_nettype wire
